// File: sv/ctc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the token classifier: class codes, character
// codes, the input item struct and the keyword rom.
// ----------------------------------------------------------------------------
package ctc_pkg;

	localparam int KW_SLOTS = 64;
	localparam int KW_CHARS = 16;

	typedef enum logic [2:0] {
		CLS_NONE    = 3'd0,
		CLS_COMMENT = 3'd1,
		CLS_KEYWORD = 3'd2,
		CLS_NUMERIC = 3'd3,
		CLS_STRING  = 3'd4,
		CLS_BRACKET = 3'd5
	} ctc_class_t;

	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPERF = 8'h46;
	localparam logic [7:0] CH_LOWERF = 8'h66;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef logic [KW_CHARS-1:0][7:0] kw_row_t;

	// one accepted item as seen by the token state logic
	typedef struct packed {
		logic       accept;
		logic [7:0] ch;
		logic       last;
		logic       has_metadata;
		logic       line_in_comment;
	} ctc_item_t;

	// keyword text, right-justified in 16 bytes; empty slots are zero
	function automatic logic [8*KW_CHARS-1:0] kw_str(input int k);
		logic [8*KW_CHARS-1:0] s;
		begin
			case (k)
				0:  s = "auto";
				1:  s = "break";
				2:  s = "case";
				3:  s = "char";
				4:  s = "const";
				5:  s = "continue";
				6:  s = "default";
				7:  s = "do";
				8:  s = "double";
				9:  s = "else";
				10: s = "enum";
				11: s = "extern";
				12: s = "float";
				13: s = "for";
				14: s = "goto";
				15: s = "if";
				16: s = "inline";
				17: s = "int";
				18: s = "long";
				19: s = "register";
				20: s = "restrict";
				21: s = "return";
				22: s = "short";
				23: s = "signed";
				24: s = "sizeof";
				25: s = "static";
				26: s = "struct";
				27: s = "switch";
				28: s = "typedef";
				29: s = "union";
				30: s = "unsigned";
				31: s = "void";
				32: s = "volatile";
				33: s = "while";
				34: s = "_Bool";
				35: s = "_Complex";
				36: s = "_Imaginary";
				default: s = '0;
			endcase
			return s;
		end
	endfunction

	// keyword characters indexed by position, zero past the end
	function automatic kw_row_t kw_row(input int k);
		logic [8*KW_CHARS-1:0] s;
		int n;
		kw_row_t r;
		begin
			s = kw_str(k);
			n = 0;
			r = '0;
			for (int i = 0; i < KW_CHARS; i++) begin
				if (s[8*i +: 8] != CH_NUL) n = i + 1;
			end
			for (int i = 0; i < KW_CHARS; i++) begin
				if (i < n) r[i] = s[8*(n-1-i) +: 8];
			end
			return r;
		end
	endfunction

	function automatic logic is_digit_or_dot(input logic [7:0] c);
		return (c == CH_DOT) || (c >= CH_ZERO && c <= CH_NINE);
	endfunction

	function automatic logic is_bracket(input logic [7:0] c);
		return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
			(c == CH_RPAREN) || (c == CH_LBRACK) || (c == CH_RBRACK);
	endfunction

endpackage

// File: sv/ctc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_if
// Valid/ready channels of the token classifier: characters in, classes out.
// ----------------------------------------------------------------------------
interface ctc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;
	logic       has_metadata;
	logic       line_in_comment;

	modport source (output valid, ch, last, has_metadata, line_in_comment, input ready);
	modport sink (input valid, ch, last, has_metadata, line_in_comment, output ready);
endinterface

interface ctc_class_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_class;

	modport source (output valid, token_class, input ready);
	modport sink (input valid, token_class, output ready);
endinterface

// File: sv/c_token_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_token_classifier
// Classifies a C token delivered one character per item; one class item is
// produced on the last character of each token.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   item
//  chars    in   ch, last, has_metadata, line_in_comment   one character
//  classes  out  token_class                               one per token
//
// one character is taken per cycle unless chars stalls; the class of a token
// is registered when its last character is taken, then offered on classes.
// reset clears the per-token state and empties the output register.
// chars stalls only while the output register holds a class that classes
// does not take in the same cycle.
module c_token_classifier import ctc_pkg::*; #(
	parameter int NUM_KEYWORDS    = 37,
	parameter int MAX_KEYWORD_LEN = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	ctc_char_if.sink         chars,
	ctc_class_if.source      classes
);

	ctc_item_t  item;
	ctc_class_t cls;
	logic       out_valid_q;
	ctc_class_t out_class_q;

	assign chars.ready = !out_valid_q || classes.ready;

	assign item.accept          = chars.valid && chars.ready;
	assign item.ch              = chars.ch;
	assign item.last            = chars.last;
	assign item.has_metadata    = chars.has_metadata;
	assign item.line_in_comment = chars.line_in_comment;

	ctc_token_state #(
		.NUM_KEYWORDS    (NUM_KEYWORDS),
		.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
	) u_token_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.token_class (cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item.accept && item.last) begin
			out_valid_q <= 1'b1;
		end else if (classes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.accept && item.last) out_class_q <= cls;
	end

	assign classes.valid       = out_valid_q;
	assign classes.token_class = out_class_q;

endmodule

// File: sv/ctc_kw_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_kw_match
// Parallel keyword compare: one comparator per rom slot against the current
// character at the current position, gated by the live mask.
// ----------------------------------------------------------------------------
module ctc_kw_match import ctc_pkg::*; #(
	parameter int NUM_KEYWORDS    = 37,
	parameter int MAX_KEYWORD_LEN = 10
) (
	input  logic [NUM_KEYWORDS-1:0] alive,
	input  logic [3:0]              pos,
	input  logic [7:0]              ch,
	output logic [NUM_KEYWORDS-1:0] keep,
	output logic [NUM_KEYWORDS-1:0] ended
);

	logic pos_ok;
	logic [3:0] pos_next;

	// pos is 4 bits, so the row limit of 15 only matters at the top value
	assign pos_ok   = (pos < 4'(MAX_KEYWORD_LEN)) && (pos != 4'hf);
	assign pos_next = pos + 4'd1;

	for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_slot
		localparam kw_row_t ROW = kw_row(k);
		logic [7:0] kc;

		assign kc       = ROW[pos];
		assign keep[k]  = alive[k] && pos_ok && (kc != CH_NUL) && (kc == ch);
		assign ended[k] = keep[k] && (ROW[pos_next] == CH_NUL);
	end

endmodule

// File: sv/ctc_token_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_token_state
// Per-token state registers and the class decision made on the last item.
// ----------------------------------------------------------------------------
module ctc_token_state import ctc_pkg::*; #(
	parameter int NUM_KEYWORDS    = 37,
	parameter int MAX_KEYWORD_LEN = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctc_item_t  item,
	output ctc_class_t token_class
);

	logic [NUM_KEYWORDS-1:0] keyword_alive_q;
	logic [3:0]              char_position_q;
	logic                    numeric_ok_q;
	logic [7:0]              first_char_q;
	logic                    slash_pair_q;

	logic [NUM_KEYWORDS-1:0] keep;
	logic [NUM_KEYWORDS-1:0] ended;
	logic [7:0]              first;
	logic                    slash2;
	logic                    is_comment;
	logic                    is_keyword;
	logic                    is_numeric;
	logic                    is_string;
	logic                    is_brkt;

	ctc_kw_match #(
		.NUM_KEYWORDS    (NUM_KEYWORDS),
		.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
	) u_kw_match (
		.alive (keyword_alive_q),
		.pos   (char_position_q),
		.ch    (item.ch),
		.keep  (keep),
		.ended (ended)
	);

	assign first  = (char_position_q == 4'd0) ? item.ch : first_char_q;
	assign slash2 = (char_position_q == 4'd1) ?
		((first_char_q == CH_SLASH) && (item.ch == CH_SLASH)) : slash_pair_q;

	assign is_comment = (item.has_metadata && item.line_in_comment) ||
		((char_position_q != 4'd0) && slash2);
	assign is_keyword = |ended;
	assign is_numeric = numeric_ok_q &&
		(is_digit_or_dot(item.ch) || item.ch == CH_LOWERF || item.ch == CH_UPPERF);
	// quotes only count when no line metadata comes with the token
	assign is_string  = !item.has_metadata &&
		(((first == CH_SQUOTE) && (item.ch == CH_SQUOTE)) ||
		((first == CH_DQUOTE) && (item.ch == CH_DQUOTE)));
	assign is_brkt    = (char_position_q == 4'd0) && is_bracket(item.ch);

	always_comb begin
		if (is_comment) begin
			token_class = CLS_COMMENT;
		end else if (is_keyword) begin
			token_class = CLS_KEYWORD;
		end else if (is_numeric) begin
			token_class = CLS_NUMERIC;
		end else if (is_string) begin
			token_class = CLS_STRING;
		end else if (is_brkt) begin
			token_class = CLS_BRACKET;
		end else begin
			token_class = CLS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_alive_q <= '1;
			char_position_q <= 4'd0;
			numeric_ok_q    <= 1'b1;
			first_char_q    <= 8'd0;
			slash_pair_q    <= 1'b0;
		end else if (item.accept) begin
			if (item.last) begin
				keyword_alive_q <= '1;
				char_position_q <= 4'd0;
				numeric_ok_q    <= 1'b1;
				first_char_q    <= 8'd0;
				slash_pair_q    <= 1'b0;
			end else begin
				keyword_alive_q <= keep;
				if (!is_digit_or_dot(item.ch)) numeric_ok_q <= 1'b0;
				first_char_q    <= first;
				slash_pair_q    <= (char_position_q != 4'd0) && slash2;
				// saturate so very long tokens stay dead for keywords
				if (char_position_q != 4'hf) char_position_q <= char_position_q + 4'd1;
			end
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Token classifier testbench. Tokens are sent one character per item, first
// as a short run of hand-picked corner tokens, then keyword variants and
// random tokens of every class, with random gaps and output stalls. A local
// model of the keyword mask and the per-token flags predicts the class of
// each token, and every class item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import ctc_pkg::*;

	localparam int KW_COUNT     = 37;
	localparam int KW_MAX_LEN   = 10;
	localparam int ITEM_TARGET  = 500;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef bit [7:0] char_t;

	typedef enum int {
		TK_KEYWORD,
		TK_KW_VARIANT,
		TK_NUMERIC,
		TK_STRING,
		TK_COMMENT,
		TK_BRACKET,
		TK_RAW,
		TK_LONG,
		TK_WORD
	} tok_kind_t;

	logic clk;
	logic arst_n;

	ctc_char_if  chars_if ();
	ctc_class_if classes_if ();

	c_token_classifier #(
		.NUM_KEYWORDS    (KW_COUNT),
		.MAX_KEYWORD_LEN (KW_MAX_LEN)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.classes (classes_if)
	);

	string c_keywords [KW_COUNT] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"inline", "int", "long", "register", "restrict", "return", "short",
		"signed", "sizeof", "static", "struct", "switch", "typedef", "union",
		"unsigned", "void", "volatile", "while", "_Bool", "_Complex", "_Imaginary"
	};

	string digit_chars = "0123456789.";
	string word_chars  = "abcdefghilnorstuvwxyz_BCI";
	string brackets    = "{}()[]";

	// per-token state of the local model
	logic [KW_COUNT-1:0] tok_kw_live;
	logic [3:0]          tok_pos;
	bit                  tok_num_ok;
	logic [7:0]          tok_first;
	bit                  tok_slash2;

	ctc_class_t expected_classes [$];

	int mismatches  = 0;
	int chars_sent  = 0;
	int cycle_count = 0;
	int ready_hold  = 0;
	bit no_idle     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit num_char(input logic [7:0] c);
		return c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE);
	endfunction

	function automatic bit bracket_char(input logic [7:0] c);
		return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
			c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK;
	endfunction

	function automatic void clear_token();
		tok_kw_live = '1;
		tok_pos     = '0;
		tok_num_ok  = 1'b1;
		tok_first   = '0;
		tok_slash2  = 1'b0;
	endfunction

	// advances the token state by one character; returns 1 when a class is due
	function automatic bit classify_char(input logic [7:0] c, input bit lst, input bit md,
			input bit mdc, output ctc_class_t cls);
		logic [KW_COUNT-1:0] live;
		logic [KW_COUNT-1:0] done;
		logic [7:0] first;
		bit slash2;
		bit numeric;
		bit strlit;
		int p;
		int k;
		p = tok_pos;
		first = (p == 0) ? c : tok_first;
		slash2 = (p == 1) ? (tok_first == CH_SLASH && c == CH_SLASH) : tok_slash2;
		live = tok_kw_live;
		done = '0;
		cls = CLS_NONE;
		for (k = 0; k < KW_COUNT; k++) begin
			if (live[k] && p < KW_MAX_LEN && p < c_keywords[k].len() &&
					c_keywords[k][p] == c) begin
				if (p + 1 == c_keywords[k].len()) done[k] = 1'b1;
			end else begin
				live[k] = 1'b0;
			end
		end
		if (!lst) begin
			tok_kw_live = live;
			if (!num_char(c)) tok_num_ok = 1'b0;
			tok_first = first;
			tok_slash2 = (p >= 1) && slash2;
			tok_pos = (p < 15) ? tok_pos + 4'd1 : 4'd15;
			return 1'b0;
		end
		numeric = tok_num_ok && (num_char(c) || c == CH_LOWERF || c == CH_UPPERF);
		strlit = !md && ((first == CH_SQUOTE && c == CH_SQUOTE) ||
			(first == CH_DQUOTE && c == CH_DQUOTE));
		if ((md && mdc) || (p >= 1 && slash2)) cls = CLS_COMMENT;
		else if (|done) cls = CLS_KEYWORD;
		else if (numeric) cls = CLS_NUMERIC;
		else if (strlit) cls = CLS_STRING;
		else if (p == 0 && bracket_char(c)) cls = CLS_BRACKET;
		else cls = CLS_NONE;
		clear_token();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_char(input char_t c, input bit lst, input bit md, input bit mdc);
		int gap;
		ctc_class_t cls;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid           <= 1'b1;
		chars_if.ch              <= c;
		chars_if.last            <= lst;
		chars_if.has_metadata    <= md;
		chars_if.line_in_comment <= mdc;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		if (classify_char(c, lst, md, mdc, cls)) expected_classes.push_back(cls);
		chars_sent++;
	endtask

	task automatic chars_idle();
		chars_if.valid <= 1'b0;
	endtask

	// metadata flags on inner characters are noise; only the last one counts
	task automatic send_bytes(input char_t t[$], input bit md, input bit mdc);
		foreach (t[i]) begin
			if (i == t.size() - 1) send_char(t[i], 1'b1, md, mdc);
			else send_char(t[i], 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic send_token(input string s, input bit md, input bit mdc);
		char_t t[$];
		for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
		send_bytes(t, md, mdc);
	endtask

	task automatic wait_for_classes();
		do @(posedge clk); while (expected_classes.size() != 0);
	endtask

	function automatic char_t pick(input string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	function automatic void keyword_variant(input int k, ref char_t t[$]);
		int n;
		t.delete();
		for (int i = 0; i < c_keywords[k].len(); i++) t.push_back(c_keywords[k][i]);
		n = t.size();
		case ($urandom_range(0, 5))
			0: if (n > 1) void'(t.pop_back());
			1: t.push_back(pick(word_chars));
			2: t[$urandom_range(0, n - 1)] = pick(word_chars);
			3: t.push_front(pick(word_chars));
			default: ;
		endcase
	endfunction

	function automatic void build_token(ref char_t t[$]);
		tok_kind_t kind;
		int n;
		int kw;
		char_t q;
		t.delete();
		kind = tok_kind_t'($urandom_range(0, 8));
		case (kind)
			TK_KEYWORD: begin
				n = $urandom_range(0, KW_COUNT - 1);
				for (int i = 0; i < c_keywords[n].len(); i++) t.push_back(c_keywords[n][i]);
			end
			TK_KW_VARIANT: keyword_variant($urandom_range(0, KW_COUNT - 1), t);
			TK_NUMERIC: begin
				n = $urandom_range(1, 6);
				repeat (n) t.push_back(pick(digit_chars));
				if ($urandom_range(0, 3) == 0) t[n - 1] = $urandom_range(0, 1) ? CH_LOWERF : CH_UPPERF;
				if ($urandom_range(0, 5) == 0) t[$urandom_range(0, n - 1)] = pick(word_chars);
			end
			TK_STRING: begin
				q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
				t.push_back(q);
				if ($urandom_range(0, 4) != 0) begin
					repeat ($urandom_range(0, 5)) t.push_back(8'($urandom_range(0, 255)));
					case ($urandom_range(0, 5))
						0: t.push_back(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
						1: t.push_back(pick(word_chars));
						default: t.push_back(q);
					endcase
				end
			end
			TK_COMMENT: begin
				t.push_back(CH_SLASH);
				case ($urandom_range(0, 3))
					0: ;
					1: t.push_back(8'($urandom_range(0, 255)));
					default: begin
						t.push_back(CH_SLASH);
						repeat ($urandom_range(0, 5)) t.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end
			TK_BRACKET: begin
				t.push_back(pick(brackets));
				if ($urandom_range(0, 3) == 0) t.push_back(pick(brackets));
			end
			TK_RAW: repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
			TK_LONG: begin
				// past the keyword length limit, and at times past the position saturation
				n = $urandom_range(11, 20);
				case ($urandom_range(0, 2))
					0: begin
						kw = $urandom_range(0, KW_COUNT - 1);
						for (int i = 0; i < c_keywords[kw].len(); i++) t.push_back(c_keywords[kw][i]);
						while (t.size() < n) t.push_back(pick(word_chars));
					end
					1: repeat (n) t.push_back(pick(digit_chars));
					default: repeat (n) t.push_back(pick(word_chars));
				endcase
			end
			default: repeat ($urandom_range(1, 4)) t.push_back(pick(word_chars));
		endcase
	endfunction

	task automatic test_special_tokens();
		send_token("if", 1'b0, 1'b0);
		send_token("//", 1'b1, 1'b0);
		send_token("x", 1'b1, 1'b1);
		send_token("x", 1'b0, 1'b1);
		send_token("'", 1'b0, 1'b0);
		send_token("\"", 1'b1, 1'b0);
		send_token("f", 1'b0, 1'b0);
		send_token("1.F", 1'b0, 1'b0);
		send_token("{", 1'b1, 1'b0);
		send_token("\"a\"", 1'b0, 1'b0);
		send_char(CH_NUL, 1'b1, 1'b0, 1'b0);
		send_char(8'hff, 1'b1, 1'b1, 1'b1);
		// comment wins over keyword
		send_token("if", 1'b1, 1'b1);
	endtask

	task automatic test_keyword_variants();
		char_t t[$];
		for (int k = 0; k < KW_COUNT; k++) begin
			if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
			keyword_variant(k, t);
			send_bytes(t, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_random_tokens(input int item_goal);
		char_t t[$];
		while (chars_sent < item_goal) begin
			if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
			build_token(t);
			send_bytes(t, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_drain_pause();
		char_t t[$];
		repeat (3) begin
			build_token(t);
			send_bytes(t, 1'b0, 1'b0);
		end
		chars_idle();
		wait_for_classes();
	endtask

	// output side: stall for a random number of cycles, possibly none, after each
	// class item, and now and then while nothing is offered
	always @(posedge clk) begin : class_ready_drive
		int hold;
		hold = no_idle ? 0 : $urandom_range(0, 7);
		if (classes_if.valid && classes_if.ready) begin
			if (hold != 0) begin
				classes_if.ready <= 1'b0;
				ready_hold <= hold - 1;
			end
		end else if (!classes_if.ready) begin
			if (ready_hold == 0) classes_if.ready <= 1'b1;
			else ready_hold <= ready_hold - 1;
		end else if (hold != 0 && $urandom_range(0, 7) == 0) begin
			classes_if.ready <= 1'b0;
			ready_hold <= hold - 1;
		end
	end

	always @(posedge clk) begin : class_check
		ctc_class_t want;
		if (arst_n && classes_if.valid && classes_if.ready) begin
			if (expected_classes.size() == 0) begin
				report_mismatch($sformatf("class item %0d with no token pending",
					classes_if.token_class));
			end else begin
				want = expected_classes.pop_front();
				if (classes_if.token_class !== want)
					report_mismatch($sformatf("token_class got %0d, expected %0d (%s)",
						classes_if.token_class, want, want.name()));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n                   = 1'b0;
		chars_if.valid           = 1'b0;
		chars_if.ch              = '0;
		chars_if.last            = 1'b0;
		chars_if.has_metadata    = 1'b0;
		chars_if.line_in_comment = 1'b0;
		classes_if.ready         = 1'b0;
		clear_token();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_tokens();
		test_keyword_variants();
		test_random_tokens(ITEM_TARGET / 2);
		test_drain_pause();
		test_random_tokens(ITEM_TARGET);

		chars_idle();
		wait_for_classes();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/ctc_pkg.sv
sv/ctc_if.sv
sv/ctc_kw_match.sv
sv/ctc_token_state.sv
sv/c_token_classifier.sv
test/tb_top.sv
